// ===== hw/rtl/flow_record_aggregator_defines.svh =====
// assertion macros used by the flow aggregator controller
`ifndef FLOW_RECORD_AGGREGATOR_DEFINES_SVH
`define FLOW_RECORD_AGGREGATOR_DEFINES_SVH

// implication checked on every clock edge outside reset
`define FRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define FRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/fra_pkg.sv =====
// package for the flow record aggregator: widths, types and state codes
`default_nettype none
package fra_pkg;
  localparam int unsigned TableEntriesDefault = 256;
  localparam int unsigned KeyW = 240;
  localparam int unsigned CntW = 64;

  typedef logic [KeyW-1:0] key_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StCmp,
    StWrite,
    StOut
  } fra_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_idx;
    logic inc_idx;
    logic do_hit;
    logic do_new;
    logic do_drop;
    logic out_load;
    logic out_clear;
  } fra_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic match;
    logic at_end;
    logic full;
  } fra_stat_t;

  function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                              input logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/fra_if.sv =====
// handshake channel interfaces for flow records and results
`default_nettype none
interface fra_rec_if;
  logic        valid;
  logic        ready;
  logic [7:0]  device_id;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [31:0] next_hop;
  logic [31:0] interfaces;
  logic [31:0] ports;
  logic [23:0] flags_proto_tos;
  logic [31:0] as_numbers;
  logic [15:0] prefix_masks;
  logic [31:0] packets;
  logic [31:0] octets;
  logic        last_record;
  modport source (output valid, device_id, src_addr, dst_addr, next_hop, interfaces, ports,
                  flags_proto_tos, as_numbers, prefix_masks, packets, octets, last_record,
                  input ready);
  modport sink (input valid, device_id, src_addr, dst_addr, next_hop, interfaces, ports,
                flags_proto_tos, as_numbers, prefix_masks, packets, octets, last_record,
                output ready);
endinterface

interface fra_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  entry_index;
  logic        created;
  logic        dropped;
  logic [63:0] total_packets;
  logic [63:0] total_octets;
  logic        last_out;
  modport source (output valid, entry_index, created, dropped, total_packets, total_octets,
                  last_out, input ready);
  modport sink (input valid, entry_index, created, dropped, total_packets, total_octets,
                last_out, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/flow_record_aggregator.sv =====
// result: on a hit the item is registered when the compare at the matching entry succeeds,
// on a miss or drop when the search index reaches the fill count
// the search walks the table one entry at a time (registered memory read, then compare)
// one item at a time: a new record is accepted only after the result item is taken
// reset: fill count cleared so the table is empty, no clearing pass; table contents undefined
`default_nettype none
module flow_record_aggregator import fra_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDefault
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  fra_rec_if.sink   rec,
  fra_res_if.source res
);
  fra_cmd_t  cmd;
  fra_stat_t stat;

  fra_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(rec.valid), .in_ready_o(rec.ready),
    .out_valid_o(res.valid), .out_ready_i(res.ready),
    .stat_i(stat), .cmd_o(cmd)
  );

  fra_datapath #(.TableEntries(TableEntries)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .stat_o(stat), .rec(rec),
    .entry_index_o(res.entry_index), .created_o(res.created), .dropped_o(res.dropped),
    .total_packets_o(res.total_packets), .total_octets_o(res.total_octets),
    .last_out_o(res.last_out)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/fra_datapath.sv =====
// datapath: key register, table memories, search index, fill count, result register
`default_nettype none
module fra_datapath import fra_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDefault
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  fra_cmd_t     cmd_i,
  output fra_stat_t    stat_o,
  fra_rec_if.sink      rec,
  output logic [7:0]   entry_index_o,
  output logic         created_o,
  output logic         dropped_o,
  output logic [63:0]  total_packets_o,
  output logic [63:0]  total_octets_o,
  output logic         last_out_o
);
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned UseW = $clog2(TableEntries + 1);

  key_t              key_mem [TableEntries];
  logic [CntW-1:0]   pkt_mem [TableEntries];
  logic [CntW-1:0]   oct_mem [TableEntries];

  key_t              key_q;
  logic [31:0]       pk_q, oc_q;
  logic              last_q;
  logic [UseW-1:0]   used_q;
  logic [UseW-1:0]   idx_q;
  key_t              rd_key_q;
  logic [CntW-1:0]   rd_pkt_q, rd_oct_q;
  logic [CntW-1:0]   sum_pk, sum_oc;
  logic [IdxW-1:0]   wr_addr;

  assign sum_pk  = sat_add(rd_pkt_q, {32'd0, pk_q});
  assign sum_oc  = sat_add(rd_oct_q, {32'd0, oc_q});
  assign wr_addr = idx_q[IdxW-1:0];

  assign stat_o.match  = (rd_key_q == key_q);
  assign stat_o.at_end = (idx_q >= used_q);
  assign stat_o.full   = (used_q == UseW'(TableEntries));

  // capture the incoming record
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= {rec.src_addr, rec.dst_addr, rec.next_hop, rec.interfaces, rec.ports,
                 rec.as_numbers, rec.device_id, rec.flags_proto_tos, rec.prefix_masks};
      pk_q   <= rec.packets;
      oc_q   <= rec.octets;
      last_q <= rec.last_record;
    end
  end

  // search index and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      used_q <= '0;
    end else begin
      if (cmd_i.clr_idx) idx_q <= '0;
      else if (cmd_i.inc_idx) idx_q <= idx_q + UseW'(1);
      if (cmd_i.do_new) used_q <= used_q + UseW'(1);
    end
  end

  // table memories, registered read at the search index
  always_ff @(posedge clk_i) begin
    rd_key_q <= key_mem[wr_addr];
    rd_pkt_q <= pkt_mem[wr_addr];
    rd_oct_q <= oct_mem[wr_addr];
    if (cmd_i.do_new) begin
      key_mem[wr_addr] <= key_q;
      pkt_mem[wr_addr] <= {32'd0, pk_q};
      oct_mem[wr_addr] <= {32'd0, oc_q};
    end else if (cmd_i.do_hit) begin
      pkt_mem[wr_addr] <= sum_pk;
      oct_mem[wr_addr] <= sum_oc;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      last_out_o <= last_q;
      if (cmd_i.do_drop) begin
        entry_index_o   <= '0;
        created_o       <= 1'b0;
        dropped_o       <= 1'b1;
        total_packets_o <= '0;
        total_octets_o  <= '0;
      end else if (cmd_i.do_new) begin
        entry_index_o   <= 8'(idx_q);
        created_o       <= 1'b1;
        dropped_o       <= 1'b0;
        total_packets_o <= {32'd0, pk_q};
        total_octets_o  <= {32'd0, oc_q};
      end else begin
        entry_index_o   <= 8'(idx_q);
        created_o       <= 1'b0;
        dropped_o       <= 1'b0;
        total_packets_o <= sum_pk;
        total_octets_o  <= sum_oc;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/fra_ctrl.sv =====
// controller: search, update or append (or drop when full), then hand out the result item
`default_nettype none
`include "flow_record_aggregator_defines.svh"
module fra_ctrl import fra_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  input  fra_stat_t  stat_i,
  output fra_cmd_t   cmd_o
);
  fra_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.clr_idx = 1'b1;
          state_d       = StRead;
        end
      end
      StRead: begin
        if (stat_i.at_end) begin
          cmd_o.out_load = 1'b1;
          if (stat_i.full) cmd_o.do_drop = 1'b1;
          else cmd_o.do_new = 1'b1;
          state_d = StOut;
        end else begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        if (stat_i.match) begin
          cmd_o.do_hit   = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d        = StOut;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d       = StRead;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  `FRA_ASSERT_IMP(a_one_update, clk_i, rst_ni, 1'b1, $countones({cmd_o.do_hit, cmd_o.do_new, cmd_o.do_drop}) <= 1)
  `FRA_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, cmd_o.out_load, out_valid_o)
  `FRA_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, out_valid_o, !in_ready_o)
endmodule
`default_nettype wire
